FILE: hdl/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Shared sizes, register codes, types and the exponent table of the
// nucleus sampler.
// ----------------------------------------------------------------------------
package nps_pkg;

  // vector storage
  localparam int MAX_ITEMS = 256;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  // sort entry: {weight, index}
  localparam int ENT_W     = 16 + IDX_W;
  localparam int TOT_W     = 16 + CNT_W;
  localparam int LIM_W     = TOT_W + 16;

  // log2(e) in Q.16, truncated
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  // register indexes
  localparam logic [0:0] CFG_INV_TEMP = 1'b0;
  localparam logic [0:0] CFG_NUC_THR  = 1'b1;

  localparam logic [15:0] INV_TEMP_RST = 16'd5120;
  localparam logic [15:0] NUC_THR_RST  = 16'd58982;

  typedef struct packed {
    logic [15:0] inv_temp;
    logic [15:0] nuc_thr;
  } cfg_t;

  // one finished vector handed from front to back
  typedef struct packed {
    logic [CNT_W-1:0]  n;
    logic signed [15:0] max_score;
    logic [15:0]       draw;
  } job_t;

  // back status seen by the front
  typedef struct packed {
    logic score_busy;
    logic idle;
  } bstat_t;

  typedef struct packed {
    logic [7:0] chosen;
    logic [8:0] count;
  } result_t;

  // round(65536 * 2^(-i/16))
  function automatic logic [16:0] pow2_tab(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/top_p_nucleus_sampler.sv
// ----------------------------------------------------------------------------
// top_p_nucleus_sampler
// Top-p sampler: score store, weight/sort/walk engine and result queue.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue (in_push/in_full): one signed Q8.8 score per item; the item
//   with in_last_logit high ends the vector and carries in_draw. Up to 256
//   scores are stored, later ones are dropped but a last item still ends it.
//   Result queue (out_empty/out_pop): one item per vector with the chosen
//   index and the nucleus size.
//   Scores load at one per cycle while in_full is low. After the last score,
//   the back takes the vector, computes the weights, runs the radix sort and
//   the two walks over the sorted buffer, and then emits the result. in_full
//   is high while a finished vector waits for the back and while the back
//   reads the score store; the next vector may load during sorting and the
//   walks.
//   A stalled receiver fills the two-entry result queue, then the back holds
//   its result and stops taking vectors.
//   Reset (rst_n low, synchronous) empties all queues, restores both
//   registers and clears the vector count. Write cfg_* only while idle.
// ----------------------------------------------------------------------------
module top_p_nucleus_sampler import nps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_logit,
  input  logic        in_last_logit,
  input  logic [15:0] in_draw,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_chosen_index,
  output logic [8:0]  out_nucleus_count
);

  cfg_t             cfg_r;
  bstat_t           bstat;
  logic             job_valid, job_take;
  job_t             job;
  logic [IDX_W-1:0] score_rd_addr;
  logic [15:0]      score_rd_data;
  logic             res_push, res_full;
  result_t          res, out_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_temp <= INV_TEMP_RST;
      cfg_r.nuc_thr  <= NUC_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INV_TEMP: cfg_r.inv_temp <= cfg_data;
        CFG_NUC_THR:  cfg_r.nuc_thr  <= cfg_data;
        default: ;
      endcase
    end
  end

  nps_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_logit      (in_logit),
    .in_last_logit (in_last_logit),
    .in_draw       (in_draw),
    .bstat         (bstat),
    .job_valid     (job_valid),
    .job           (job),
    .job_take      (job_take),
    .score_rd_addr (score_rd_addr),
    .score_rd_data (score_rd_data)
  );

  nps_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .job_valid     (job_valid),
    .job           (job),
    .job_take      (job_take),
    .bstat         (bstat),
    .score_rd_addr (score_rd_addr),
    .score_rd_data (score_rd_data),
    .res_push      (res_push),
    .res           (res),
    .res_full      (res_full)
  );

  nps_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (out_res)
  );

  assign out_chosen_index  = out_res.chosen;
  assign out_nucleus_count = out_res.count;

  // score store is never written while the back reads it
  a_store_guard: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.score_busy |-> in_full)
    else $error("input accepted while scores are read");

  // a job is only taken by an idle back
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |-> (bstat.idle && job_valid))
    else $error("job taken while back busy");

  // back goes busy right after taking a job
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |=> bstat.score_busy)
    else $error("back did not start weights");

  // every result has a nonempty nucleus
  a_nuc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (res.count != 9'd0))
    else $error("empty nucleus");

endmodule

FILE: hdl/nps_front.sv
// ----------------------------------------------------------------------------
// nps_front
// Accepts scores, stores them, tracks the maximum and count, and hands a
// finished vector to the back through a one-entry job register.
// ----------------------------------------------------------------------------
module nps_front import nps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [15:0]        in_logit,
  input  logic               in_last_logit,
  input  logic [15:0]        in_draw,
  input  bstat_t             bstat,
  output logic               job_valid,
  output job_t               job,
  input  logic               job_take,
  input  logic [IDX_W-1:0]   score_rd_addr,
  output logic [15:0]        score_rd_data
);

  logic [15:0]        score_mem [MAX_ITEMS];
  logic [15:0]        score_rd_r;
  logic [CNT_W-1:0]   cnt_r;
  logic signed [15:0] max_r;
  logic               job_v_r;
  job_t               job_r;
  logic               accept;
  logic               room;
  logic signed [15:0] max_nxt;
  logic [CNT_W-1:0]   cnt_nxt;

  // front stalls while a job waits or the back still reads scores
  assign in_full = job_v_r | bstat.score_busy;
  assign accept  = in_push & ~in_full;
  assign room    = cnt_r < CNT_W'(MAX_ITEMS);

  always_comb begin
    max_nxt = max_r;
    cnt_nxt = cnt_r;
    if (room) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if ($signed(in_logit) > max_r) max_nxt = $signed(in_logit);
    end
  end

  // score store
  always_ff @(posedge clk) begin
    if (accept && room) score_mem[cnt_r[IDX_W-1:0]] <= in_logit;
    score_rd_r <= score_mem[score_rd_addr];
  end

  // vector tracking and job handoff
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      max_r   <= -16'sd32768;
      job_v_r <= 1'b0;
    end else begin
      if (job_take) job_v_r <= 1'b0;
      if (accept) begin
        if (in_last_logit) begin
          job_v_r         <= 1'b1;
          job_r.n         <= cnt_nxt;
          job_r.max_score <= max_nxt;
          job_r.draw      <= in_draw;
          cnt_r           <= '0;
          max_r           <= -16'sd32768;
        end else begin
          cnt_r <= cnt_nxt;
          max_r <= max_nxt;
        end
      end
    end
  end

  assign job_valid     = job_v_r;
  assign job           = job_r;
  assign score_rd_data = score_rd_r;

endmodule

FILE: hdl/nps_back.sv
// ----------------------------------------------------------------------------
// nps_back
// Weight pipeline, four-pass radix sort (4-bit digits, descending, stable),
// nucleus walk and sample walk over the sorted buffer.
// ----------------------------------------------------------------------------
module nps_back import nps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             job_valid,
  input  job_t             job,
  output logic             job_take,
  output bstat_t           bstat,
  output logic [IDX_W-1:0] score_rd_addr,
  input  logic [15:0]      score_rd_data,
  output logic             res_push,
  output result_t          res,
  input  logic             res_full
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_WGT  = 10'b0000000010,
    S_HIST = 10'b0000000100,
    S_PREF = 10'b0000001000,
    S_SCAT = 10'b0000010000,
    S_NSET = 10'b0000100000,
    S_NUC  = 10'b0001000000,
    S_SSET = 10'b0010000000,
    S_SMP  = 10'b0100000000,
    S_EMIT = 10'b1000000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   n_r;
  logic signed [15:0] max_r;
  logic [15:0]        draw_r;
  logic [CNT_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   rd_lim;
  logic               issue;
  logic               rv_r;

  // weight pipeline
  logic [3:0]         pv_r;
  logic [IDX_W-1:0]   idx_r [4];
  logic [31:0]        x_r;
  logic [32:0]        y_r;
  logic [27:0]        ip_r;
  logic [12:0]        k_r;
  logic [16:0]        ti_r;
  logic [TOT_W-1:0]   total_r;
  logic [16:0]        dsg;
  logic [31:0]        x_nxt;
  logic [48:0]        y_full;
  logic [16:0]        ti, tn, tdiff;
  logic [16:0]        rnd, m;
  logic [17:0]        mr;
  logic [15:0]        w_new;

  // sort
  logic [ENT_W-1:0]   buf_a [MAX_ITEMS];
  logic [ENT_W-1:0]   buf_b [MAX_ITEMS];
  logic [ENT_W-1:0]   a_rd_r, b_rd_r;
  logic [1:0]         pass_r;
  logic [CNT_W-1:0]   cnt_r [16];
  logic [4:0]         pref_r;
  logic [CNT_W-1:0]   acc_r;
  logic [ENT_W-1:0]   src;
  logic [15:0]        key;
  logic [3:0]         dig;
  logic               a_we, b_we;
  logic [IDX_W-1:0]   a_waddr;
  logic [ENT_W-1:0]   a_wdata;
  logic [IDX_W-1:0]   pos;

  // walks
  logic [LIM_W-1:0]   lim_r;
  logic [TOT_W-1:0]   cum_r, cum_nxt;
  logic [CNT_W-1:0]   nuc_r, nuc_nxt;
  logic [CNT_W-1:0]   ecnt_r;
  logic [IDX_W-1:0]   top_r, chosen_r;
  logic [15:0]        a_w;
  logic [IDX_W-1:0]   a_idx;
  logic               hit;
  logic [31:0]        chosen_ext, nuc_ext;

  // read stream limit per state
  always_comb begin
    rd_lim = n_r;
    if (state_r == S_SMP) rd_lim = nuc_r;
  end

  assign issue = ((state_r == S_WGT) || (state_r == S_HIST) || (state_r == S_SCAT) ||
                  (state_r == S_NUC) || (state_r == S_SMP)) && (rd_ptr_r < rd_lim);
  assign score_rd_addr = rd_ptr_r[IDX_W-1:0];

  // stage 0: distance to max times reciprocal temperature
  assign dsg   = {max_r[15], max_r} - {score_rd_data[15], score_rd_data};
  assign x_nxt = 32'(dsg[15:0]) * 32'(cfg.inv_temp);
  // stage 1: into log2 units
  assign y_full = 49'(x_r) * 49'(LOG2E_Q16);
  // stage 2: table and interpolation product
  assign ti    = pow2_tab({1'b0, y_r[19:16]});
  assign tn    = pow2_tab({1'b0, y_r[19:16]} + 5'd1);
  assign tdiff = ti - tn;
  // stage 3: round, shift, saturate
  always_comb begin
    rnd = 17'((29'(ip_r) + 29'd32768) >> 16);
    m   = ti_r - rnd;
    mr  = (18'(m) + (18'd1 << (k_r[4:0] - 5'd1))) >> k_r[4:0];
    if (k_r >= 13'd17)      w_new = 16'd0;
    else if (k_r == 13'd0)  w_new = (m > 17'd65535) ? 16'hFFFF : m[15:0];
    else                    w_new = (mr > 18'd65535) ? 16'hFFFF : mr[15:0];
  end

  // sort digit of the current source entry
  assign src = pass_r[0] ? b_rd_r : a_rd_r;
  assign key = ~src[ENT_W-1:IDX_W];
  assign dig = key[{pass_r, 2'b00} +: 4];
  assign pos = cnt_r[dig][IDX_W-1:0];

  // walk arithmetic
  assign a_w     = a_rd_r[ENT_W-1:IDX_W];
  assign a_idx   = a_rd_r[IDX_W-1:0];
  assign cum_nxt = cum_r + TOT_W'(a_w);
  assign nuc_nxt = nuc_r + CNT_W'(1);
  assign hit     = {cum_nxt, 16'd0} >= lim_r;

  // buffer write ports
  always_comb begin
    a_we    = 1'b0;
    a_waddr = pos;
    a_wdata = src;
    b_we    = 1'b0;
    if (state_r == S_WGT) begin
      a_we    = pv_r[3];
      a_waddr = idx_r[3];
      a_wdata = {w_new, idx_r[3]};
    end else if (state_r == S_SCAT && rv_r) begin
      a_we = pass_r[0];
      b_we = ~pass_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) buf_a[a_waddr] <= a_wdata;
    if (b_we) buf_b[pos] <= src;
    a_rd_r <= buf_a[rd_ptr_r[IDX_W-1:0]];
    b_rd_r <= buf_b[rd_ptr_r[IDX_W-1:0]];
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    rd_ptr_nxt = issue ? rd_ptr_r + CNT_W'(1) : rd_ptr_r;
    case (state_r)
      S_IDLE: if (job_valid) state_nxt = S_WGT;
      S_WGT:  if (rd_ptr_r == n_r && pv_r == 4'd0) state_nxt = S_HIST;
      S_HIST: if (rd_ptr_r == n_r && !rv_r) state_nxt = S_PREF;
      S_PREF: if (pref_r == 5'd15) state_nxt = S_SCAT;
      S_SCAT: if (rd_ptr_r == n_r && !rv_r) state_nxt = (pass_r == 2'd3) ? S_NSET : S_HIST;
      S_NSET: state_nxt = S_NUC;
      S_NUC:  if (rv_r && (hit || nuc_nxt == n_r)) state_nxt = S_SSET;
      S_SSET: state_nxt = S_SMP;
      S_SMP:  if (rv_r && (hit || ecnt_r + CNT_W'(1) == nuc_r)) state_nxt = S_EMIT;
      S_EMIT: if (!res_full) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (state_nxt != state_r) rd_ptr_nxt = '0;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_ptr_r <= '0;
      rv_r     <= 1'b0;
      pv_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      rv_r     <= issue && (state_nxt == state_r);
      pv_r     <= {pv_r[2:0], issue && (state_r == S_WGT)};
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // weight pipeline
    idx_r[0] <= rd_ptr_r[IDX_W-1:0];
    idx_r[1] <= idx_r[0];
    idx_r[2] <= idx_r[1];
    idx_r[3] <= idx_r[2];
    x_r      <= x_nxt;
    y_r      <= y_full[48:16];
    ip_r     <= 28'(tdiff) * 28'(y_r[15:0]);
    k_r      <= y_r[32:20];
    ti_r     <= ti;

    case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          n_r     <= job.n;
          max_r   <= job.max_score;
          draw_r  <= job.draw;
          total_r <= '0;
          pass_r  <= 2'd0;
        end
      end
      S_WGT: begin
        if (pv_r[3]) total_r <= total_r + TOT_W'(w_new);
        if (state_nxt == S_HIST) begin
          for (int j = 0; j < 16; j++) cnt_r[j] <= '0;
        end
      end
      S_HIST: begin
        if (rv_r) cnt_r[dig] <= cnt_r[dig] + CNT_W'(1);
        pref_r <= 5'd0;
        acc_r  <= '0;
      end
      S_PREF: begin
        cnt_r[pref_r[3:0]] <= acc_r;
        acc_r  <= acc_r + cnt_r[pref_r[3:0]];
        pref_r <= pref_r + 5'd1;
      end
      S_SCAT: begin
        if (rv_r) cnt_r[dig] <= cnt_r[dig] + CNT_W'(1);
        if (state_nxt == S_HIST) begin
          pass_r <= pass_r + 2'd1;
          for (int j = 0; j < 16; j++) cnt_r[j] <= '0;
        end
      end
      S_NSET: begin
        lim_r <= LIM_W'(cfg.nuc_thr) * LIM_W'(total_r);
        cum_r <= '0;
        nuc_r <= '0;
      end
      S_NUC: begin
        if (rv_r) begin
          cum_r <= cum_nxt;
          nuc_r <= nuc_nxt;
        end
      end
      S_SSET: begin
        lim_r  <= LIM_W'(draw_r) * LIM_W'(cum_r);
        cum_r  <= '0;
        ecnt_r <= '0;
      end
      S_SMP: begin
        if (rv_r) begin
          cum_r  <= cum_nxt;
          ecnt_r <= ecnt_r + CNT_W'(1);
          if (ecnt_r == '0) top_r <= a_idx;
          if (hit) chosen_r <= a_idx;
          else chosen_r <= (ecnt_r == '0) ? a_idx : top_r;
        end
      end
      default: ;
    endcase
  end

  assign job_take         = (state_r == S_IDLE) && job_valid;
  assign bstat.score_busy = (state_r == S_WGT);
  assign bstat.idle       = (state_r == S_IDLE);

  assign chosen_ext = 32'(chosen_r);
  assign nuc_ext    = 32'(nuc_r);
  assign res_push   = (state_r == S_EMIT) && !res_full;
  assign res.chosen = chosen_ext[7:0];
  assign res.count  = nuc_ext[8:0];

endmodule

FILE: hdl/nps_outq.sv
// ----------------------------------------------------------------------------
// nps_outq
// Two-entry result queue between the back and the result port.
// ----------------------------------------------------------------------------
module nps_outq import nps_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t wdata,
  output logic    full,
  input  logic    pop,
  output logic    empty,
  output result_t rdata
);

  result_t    q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
